@@ rtl/pdq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pdq_pkg
// Shared types and operation codes for the pair deque.
// ----------------------------------------------------------------------------
package pdq_pkg;

	localparam int unsigned OP_W   = 3;
	localparam int unsigned POS_W  = 11;
	localparam int unsigned WORD_W = 32;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_INSERT_AT  = 3'd4,
		OP_DELETE_AT  = 3'd5
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [POS_W-1:0]         position;
		logic signed [WORD_W-1:0] first_word;
		logic signed [WORD_W-1:0] second_word;
	} cmd_t;

	typedef struct packed {
		logic                     accepted;
		logic [POS_W-1:0]         entry_count;
		logic signed [WORD_W-1:0] front_first;
		logic signed [WORD_W-1:0] front_second;
		logic signed [WORD_W-1:0] back_first;
		logic signed [WORD_W-1:0] back_second;
	} res_t;

endpackage
`default_nettype wire

@@ rtl/pdq_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pdq_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface pdq_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/pdq_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pdq_front
// Accept commands and hold them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module pdq_front
	import pdq_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  cmd_t in_data,
	input  logic in_valid,
	output logic in_ready,
	output cmd_t q_data,
	output logic q_valid,
	input  logic q_take
);
	cmd_t       buf_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_take};
		end
	end
endmodule
`default_nettype wire

@@ rtl/pdq_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pdq_back
// Execute deque operations on the entry memory and register the result.
// ----------------------------------------------------------------------------
module pdq_back
	import pdq_pkg::*;
#(
	parameter int unsigned DEPTH = 1024
) (
	input  wire  clk,
	input  wire  arst_n,
	input  cmd_t cmd,
	input  logic cmd_valid,
	output logic cmd_take,
	output res_t res,
	output logic res_valid,
	input  logic res_ready
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_RD    = 7'b0000010,
		ST_MV    = 7'b0000100,
		ST_PUT   = 7'b0001000,
		ST_RDF   = 7'b0010000,
		ST_RDB   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} st_t;

	st_t st_q;
	logic [2*WORD_W-1:0] mem [DEPTH];
	logic [2*WORD_W-1:0] rdata_q;
	logic [AW-1:0] head_q, tail_q, raddr, waddr, src_q, dst_q;
	logic [CW-1:0] occ_q, left_q;
	logic          we, ins_q, ok_q, mv_wr_q;
	logic [2*WORD_W-1:0] wdata, pair_q;
	logic [WORD_W-1:0]   front_first_q, front_second_q, back_first, back_second;
	cmd_t          c_q;

	function automatic logic [AW-1:0] wrap(input logic [CW:0] v);
		logic [CW:0] d;
		d = (CW+1)'(DEPTH);
		return (v >= d) ? AW'(v - d) : AW'(v);
	endfunction

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign cmd_take  = (st_q == ST_IDLE) && cmd_valid;
	assign res_valid = (st_q == ST_OUT);

	always_comb begin
		we    = 1'b0;
		waddr = dst_q;
		wdata = rdata_q;
		raddr = src_q;
		case (st_q)
			ST_MV:  we = mv_wr_q;
			ST_PUT: begin we = 1'b1; wdata = pair_q; end
			ST_RDF: raddr = head_q;
			ST_RDB: raddr = tail_q;
			ST_OUT: raddr = tail_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			c_q    <= cmd;
			pair_q <= {cmd.second_word, cmd.first_word};
		end
		if (st_q == ST_RDB) begin
			front_first_q  <= (occ_q == '0) ? '1 : rdata_q[WORD_W-1:0];
			front_second_q <= (occ_q == '0) ? '1 : rdata_q[2*WORD_W-1:WORD_W];
		end
	end

	// tail read stays on the port while the result waits
	assign back_first  = (occ_q == '0) ? '1 : rdata_q[WORD_W-1:0];
	assign back_second = (occ_q == '0) ? '1 : rdata_q[2*WORD_W-1:WORD_W];
	assign res = {ok_q, POS_W'(occ_q), front_first_q, front_second_q,
		back_first, back_second};

	logic [CW-1:0] pos;
	logic [XW-1:0] pos_x, occ_x;
	assign pos   = CW'(c_q.position);
	assign pos_x = XW'(c_q.position);
	assign occ_x = XW'(occ_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
			ok_q    <= 1'b0;
			ins_q   <= 1'b0;
			mv_wr_q <= 1'b0;
			src_q   <= '0;
			dst_q   <= '0;
			left_q  <= '0;
		end else begin
			case (st_q)
				ST_IDLE: if (cmd_take) st_q <= ST_RD;
				ST_RD: begin
					ok_q    <= 1'b0;
					mv_wr_q <= 1'b0;
					st_q    <= ST_RDF;
					case (c_q.op)
						OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
							if (occ_q != FULL && (c_q.op != OP_INSERT_AT ||
								pos_x <= occ_x)) begin
								ok_q  <= 1'b1;
								occ_q <= occ_q + 1'b1;
								st_q  <= ST_PUT;
								if (occ_q == '0) begin
									head_q <= '0; tail_q <= '0; dst_q <= '0;
								end else if (c_q.op == OP_PUSH_FRONT ||
									(c_q.op == OP_INSERT_AT && c_q.position == '0)) begin
									head_q <= wrap({1'b0, CW'(head_q)} + CW'(DEPTH - 1));
									dst_q  <= wrap({1'b0, CW'(head_q)} + CW'(DEPTH - 1));
								end else if (c_q.op == OP_PUSH_BACK || pos == occ_q) begin
									tail_q <= wrap({1'b0, CW'(tail_q)} + 1'b1);
									dst_q  <= wrap({1'b0, CW'(tail_q)} + 1'b1);
								end else begin
									// shift tail..pos up by one, from the top
									tail_q <= wrap({1'b0, CW'(tail_q)} + 1'b1);
									dst_q  <= wrap({1'b0, CW'(tail_q)} + 1'b1);
									src_q  <= tail_q;
									left_q <= occ_q - pos;
									ins_q  <= 1'b1;
									st_q   <= ST_MV;
								end
							end
						end
						OP_POP_FRONT, OP_POP_BACK, OP_DELETE_AT: begin
							if (occ_q != '0 && (c_q.op != OP_DELETE_AT ||
								pos_x < occ_x)) begin
								ok_q  <= 1'b1;
								occ_q <= occ_q - 1'b1;
								if (occ_q == CW'(1)) begin
									head_q <= '0; tail_q <= '0;
								end else if (c_q.op == OP_POP_FRONT ||
									(c_q.op == OP_DELETE_AT && c_q.position == '0)) begin
									head_q <= wrap({1'b0, CW'(head_q)} + 1'b1);
								end else if (c_q.op == OP_POP_BACK ||
									pos == occ_q - 1'b1) begin
									tail_q <= wrap({1'b0, CW'(tail_q)} + CW'(DEPTH - 1));
								end else begin
									dst_q  <= wrap({1'b0, CW'(head_q)} + pos);
									src_q  <= wrap({1'b0, CW'(head_q)} + pos + 1'b1);
									left_q <= occ_q - pos - 1'b1;
									ins_q  <= 1'b0;
									tail_q <= wrap({1'b0, CW'(tail_q)} + CW'(DEPTH - 1));
									st_q   <= ST_MV;
								end
							end
						end
						default: ;
					endcase
				end
				// first visit only primes the read; each later visit writes the
				// entry read on the visit before
				ST_MV: begin
					mv_wr_q <= 1'b1;
					if (ins_q)
						src_q <= wrap({1'b0, CW'(src_q)} + CW'(DEPTH - 1));
					else
						src_q <= wrap({1'b0, CW'(src_q)} + 1'b1);
					if (mv_wr_q) begin
						if (ins_q)
							dst_q <= wrap({1'b0, CW'(dst_q)} + CW'(DEPTH - 1));
						else
							dst_q <= wrap({1'b0, CW'(dst_q)} + 1'b1);
						left_q <= left_q - 1'b1;
						if (left_q == CW'(1))
							st_q <= ins_q ? ST_PUT : ST_RDF;
					end
				end
				ST_PUT: st_q <= ST_RDF;
				ST_RDF: st_q <= ST_RDB;
				ST_RDB: st_q <= ST_OUT;
				ST_OUT: if (res_ready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/pair_deque_with_positional_edit_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pair_deque_with_positional_edit_top
// Circular deque of signed word pairs with positional insert and delete.
// ----------------------------------------------------------------------------
// Sequence: each command is taken in IDLE and decoded in RD; a push or insert
//   writes the pair in PUT, a middle insert or delete first shifts the entries
//   in MV after priming the read, and every operation reads front and back in
//   RDF and RDB before the result is held in OUT. Throughput: one transaction
//   in the back end at a time; a two-entry command queue keeps the input open while a result waits.
// Reset: arst_n clears indices, count and control; memory is not cleared.
// ----------------------------------------------------------------------------
module pair_deque_with_positional_edit_top
	import pdq_pkg::*;
#(
	parameter int unsigned DEPTH = 1024
) (
	input wire clk,
	input wire arst_n,
	pdq_if.sink   in_ch,
	pdq_if.source out_ch
);
	cmd_t q_data;
	logic q_valid, q_take;
	res_t res;

	// front end: take transactions into the command queue
	pdq_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_data(in_ch.data), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.q_data(q_data), .q_valid(q_valid), .q_take(q_take)
	);

	// back end: carry out each operation against the entry memory
	pdq_back #(.DEPTH(DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd(q_data), .cmd_valid(q_valid), .cmd_take(q_take),
		.res(res), .res_valid(out_ch.valid), .res_ready(out_ch.ready)
	);

	assign out_ch.data = res;
endmodule
`default_nettype wire

@@ verif/pair_deque_with_positional_edit_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_deque_with_positional_edit_top_tb
// Drives random and directed deque operations into the pair deque, keeps a
// shadow deque of word pairs, and checks every result field in order.
// ----------------------------------------------------------------------------
module pair_deque_with_positional_edit_top_tb;
	import pdq_pkg::*;

	localparam int unsigned DEPTH      = 1024;
	localparam int unsigned IDLE_LIMIT = 20000;
	localparam int unsigned SETTLE     = 2 * DEPTH + 50;

	// Unused op codes, outside the enum.
	localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

	logic clk;
	logic arst_n;

	pdq_if #(.T(cmd_t)) cmd_ch ();
	pdq_if #(.T(res_t)) res_ch ();

	pair_deque_with_positional_edit_top #(.DEPTH(DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (cmd_ch.sink),
		.out_ch (res_ch.source)
	);

	// Shadow deque: element 0 is the front entry.
	typedef struct packed {
		logic signed [WORD_W-1:0] first_word;
		logic signed [WORD_W-1:0] second_word;
	} pair_t;

	pair_t shadow_deque[$];
	cmd_t  pending_cmds[$];
	res_t  expected_results[$];

	int unsigned error_count;
	int unsigned idle_cycles;
	bit          hold_sender;
	bit          cmd_fire;
	bit          res_fire;
	int unsigned gap   = 0;
	int unsigned stall = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one operation to the shadow deque and return the result it yields.
	function automatic res_t apply_op(cmd_t c);
		res_t  r;
		pair_t p;
		int    n;
		bit    ok;
		n = shadow_deque.size();
		p.first_word  = c.first_word;
		p.second_word = c.second_word;
		ok = 1'b0;
		case (c.op)
			OP_PUSH_FRONT: begin
				if (n < DEPTH) begin
					shadow_deque.insert(0, p);
					ok = 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				if (n < DEPTH) begin
					shadow_deque.insert(n, p);
					ok = 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (n > 0) begin
					shadow_deque.delete(0);
					ok = 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (n > 0) begin
					shadow_deque.delete(n - 1);
					ok = 1'b1;
				end
			end
			OP_INSERT_AT: begin
				if (n < DEPTH && c.position <= n) begin
					shadow_deque.insert(c.position, p);
					ok = 1'b1;
				end
			end
			OP_DELETE_AT: begin
				if (n > 0 && c.position < n) begin
					shadow_deque.delete(c.position);
					ok = 1'b1;
				end
			end
			default: ok = 1'b0;
		endcase
		r.accepted    = ok;
		r.entry_count = POS_W'(shadow_deque.size());
		if (shadow_deque.size() == 0) begin
			r.front_first  = -1;
			r.front_second = -1;
			r.back_first   = -1;
			r.back_second  = -1;
		end else begin
			r.front_first  = shadow_deque[0].first_word;
			r.front_second = shadow_deque[0].second_word;
			r.back_first   = shadow_deque[$].first_word;
			r.back_second  = shadow_deque[$].second_word;
		end
		return r;
	endfunction

	function automatic cmd_t make_cmd(logic [OP_W-1:0] op, int unsigned pos,
			logic [WORD_W-1:0] w1, logic [WORD_W-1:0] w2);
		cmd_t c;
		c.op          = op;
		c.position    = pos[POS_W-1:0];
		c.first_word  = w1;
		c.second_word = w2;
		return c;
	endfunction

	function automatic void queue_cmd(cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	// Note the handshakes of the last rising edge for the falling-edge drivers.
	always @(posedge clk) begin
		cmd_fire <= cmd_ch.valid && cmd_ch.ready;
		res_fire <= res_ch.valid && res_ch.ready;
	end

	// Driver: draw a gap per transaction, present it at the falling edge, and
	// hold it until it has been taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			gap = 0;
		end else begin
			if (cmd_fire) begin
				pending_cmds.delete(0);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			end
			if (cmd_fire || !cmd_ch.valid) begin
				if (gap > 0) begin
					gap--;
					cmd_ch.valid <= 1'b0;
				end else if (pending_cmds.size() > 0 && !hold_sender) begin
					cmd_ch.data  <= pending_cmds[0];
					cmd_ch.valid <= 1'b1;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Sink side: ready waits out a random stall per result.
	always @(negedge clk) begin
		if (res_fire)
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
		if (stall > 0) begin
			res_ch.ready <= 1'b0;
			stall--;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Monitor: predict on accepted commands, compare accepted results.
	always @(posedge clk) begin
		res_t exp_r;
		res_t act_r;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready)
				expected_results.insert(expected_results.size(), apply_op(cmd_ch.data));
			if (res_ch.valid && res_ch.ready) begin
				act_r = res_ch.data;
				if (expected_results.size() == 0) begin
					$error("result with nothing expected: %p", act_r);
					error_count++;
				end else begin
					exp_r = expected_results[0];
					expected_results.delete(0);
					if (act_r.accepted !== exp_r.accepted) begin
						$error("accepted: expected %0d actual %0d",
							exp_r.accepted, act_r.accepted);
						error_count++;
					end
					if (act_r.entry_count !== exp_r.entry_count) begin
						$error("entry_count: expected %0d actual %0d",
							exp_r.entry_count, act_r.entry_count);
						error_count++;
					end
					if (act_r.front_first !== exp_r.front_first) begin
						$error("front_first: expected %0d actual %0d",
							exp_r.front_first, act_r.front_first);
						error_count++;
					end
					if (act_r.front_second !== exp_r.front_second) begin
						$error("front_second: expected %0d actual %0d",
							exp_r.front_second, act_r.front_second);
						error_count++;
					end
					if (act_r.back_first !== exp_r.back_first) begin
						$error("back_first: expected %0d actual %0d",
							exp_r.back_first, act_r.back_first);
						error_count++;
					end
					if (act_r.back_second !== exp_r.back_second) begin
						$error("back_second: expected %0d actual %0d",
							exp_r.back_second, act_r.back_second);
						error_count++;
					end
				end
			end
		end
	end

	// Watchdog: count cycles in which no transaction moves on either side.
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Return a random word; the extremes turn up now and then.
	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// Random mix; fill_bias steers between growing and shrinking the deque.
	task automatic queue_random(int unsigned count, int unsigned fill_bias,
			int unsigned max_pos);
		int unsigned k;
		int unsigned sel;
		logic [OP_W-1:0] op;
		for (k = 0; k < count; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < fill_bias)
				op = ($urandom_range(0, 2) == 0) ? OP_PUSH_FRONT :
					($urandom_range(0, 1) ? OP_PUSH_BACK : OP_INSERT_AT);
			else if (sel < 96)
				op = ($urandom_range(0, 2) == 0) ? OP_POP_FRONT :
					($urandom_range(0, 1) ? OP_POP_BACK : OP_DELETE_AT);
			else if (sel < 98)
				op = ($urandom_range(0, 1)) ? OP_UNUSED_6 : OP_UNUSED_7;
			else
				op = ($urandom_range(0, 1)) ? OP_INSERT_AT : OP_DELETE_AT;
			queue_cmd(make_cmd(op,
				(sel >= 98) ? $urandom_range(0, 2047) : $urandom_range(0, max_pos),
				rand_word(), rand_word()));
		end
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned k;
		error_count   = 0;
		idle_cycles   = 0;
		hold_sender   = 1'b0;
		arst_n        = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty pops, unused codes, positional edge cases.
		queue_cmd(make_cmd(OP_POP_FRONT, 0, 0, 0));
		queue_cmd(make_cmd(OP_POP_BACK, 0, 0, 0));
		queue_cmd(make_cmd(OP_DELETE_AT, 0, 0, 0));
		queue_cmd(make_cmd(OP_INSERT_AT, 1, 1, 1));
		queue_cmd(make_cmd(OP_UNUSED_6, 2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		queue_cmd(make_cmd(OP_PUSH_FRONT, 0, 32'h8000_0000, 32'h7FFF_FFFF));
		queue_cmd(make_cmd(OP_PUSH_BACK, 0, 32'h7FFF_FFFF, 32'h8000_0000));
		queue_cmd(make_cmd(OP_INSERT_AT, 0, 10, 11));
		queue_cmd(make_cmd(OP_INSERT_AT, 3, 20, 21));
		queue_cmd(make_cmd(OP_INSERT_AT, 2, 30, 31));
		queue_cmd(make_cmd(OP_INSERT_AT, 6, 40, 41));
		queue_cmd(make_cmd(OP_DELETE_AT, 5, 0, 0));
		queue_cmd(make_cmd(OP_DELETE_AT, 4, 0, 0));
		queue_cmd(make_cmd(OP_DELETE_AT, 1, 0, 0));
		queue_cmd(make_cmd(OP_DELETE_AT, 0, 0, 0));
		queue_cmd(make_cmd(OP_UNUSED_7, 1024, 0, 0));
		queue_cmd(make_cmd(OP_POP_BACK, 0, 0, 0));
		queue_cmd(make_cmd(OP_POP_FRONT, 0, 0, 0));
		queue_cmd(make_cmd(OP_POP_FRONT, 0, 0, 0));
		wait_drained();

		// Pause the sender mid-stream until every expected result has come.
		queue_random(40, 70, 8);
		repeat (30) @(posedge clk);
		hold_sender = 1'b1;
		while (cmd_ch.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		hold_sender = 1'b0;
		wait_drained();

		// Random, small occupancy: cheap positional edits.
		for (k = 0; k < 2; k++) begin
			queue_random(60, 55, 20);
			queue_random(30, 35, 20);
		end
		wait_drained();

		// Fill to the top with pushes, poke the full case, then shrink a little.
		for (k = 0; k < DEPTH; k++)
			queue_cmd(make_cmd(k[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
				0, rand_word(), rand_word()));
		queue_cmd(make_cmd(OP_PUSH_FRONT, 0, 5, 5));
		queue_cmd(make_cmd(OP_PUSH_BACK, 0, 6, 6));
		queue_cmd(make_cmd(OP_INSERT_AT, 1024, 7, 7));
		queue_cmd(make_cmd(OP_INSERT_AT, 512, 8, 8));
		queue_cmd(make_cmd(OP_DELETE_AT, 1024, 0, 0));
		queue_cmd(make_cmd(OP_DELETE_AT, 1023, 0, 0));
		queue_cmd(make_cmd(OP_INSERT_AT, 1, 9, 9));
		queue_cmd(make_cmd(OP_DELETE_AT, 1, 0, 0));
		queue_cmd(make_cmd(OP_DELETE_AT, 700, 0, 0));
		for (k = 0; k < 60; k++)
			queue_cmd(make_cmd((k % 3 == 0) ? OP_DELETE_AT :
				(k[0] ? OP_POP_BACK : OP_POP_FRONT),
				$urandom_range(0, 1000), 0, 0));
		wait_drained();

		repeat (SETTLE) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
